FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, switched off while rst_n is low.
`define SKD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on clk that stays live through reset.
`define SKD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/skd_pkg.sv
package skd_pkg;

  // Field widths
  localparam int ID_W     = 8;
  localparam int PWR_W    = 16;
  localparam int CFG_W    = 16;
  localparam int ID_RANGE = 2 ** ID_W;

  // Default number of tracked transmitters
  localparam int MAX_DRONES_DEF = 256;

  // Shared arithmetic widths: 17-bit divider and multiplier operands
  localparam int DIV_W     = 17;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int MUL_W     = 17;
  localparam int PROD_W    = 2 * MUL_W;

  // Configuration register map
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_PROCESS_NOISE         = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] CFG_MEASUREMENT_NOISE     = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] CFG_INITIAL_VARIANCE      = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] CFG_CORRECTION_THRESHOLD  = CFG_AW'(3);
  localparam logic [CFG_AW-1:0] CFG_CONSISTENCY_THRESHOLD = CFG_AW'(4);

  // Register reset values (Q8.8)
  localparam logic [CFG_W-1:0] RST_PROCESS_NOISE         = 16'd3;
  localparam logic [CFG_W-1:0] RST_MEASUREMENT_NOISE     = 16'd1024;
  localparam logic [CFG_W-1:0] RST_INITIAL_VARIANCE      = 16'd2560;
  localparam logic [CFG_W-1:0] RST_CORRECTION_THRESHOLD  = 16'd1536;
  localparam logic [CFG_W-1:0] RST_CONSISTENCY_THRESHOLD = 16'd1697;

  // Gain of one in Q1.16 and the rounding half for a >>16
  localparam logic [MUL_W-1:0]  K_ONE      = 17'h10000;
  localparam logic [PROD_W-1:0] ROUND_HALF = 34'd32768;

  typedef struct packed {
    logic [ID_W-1:0]         drone_id;
    logic signed [PWR_W-1:0] measured_power;
  } skd_in_t;

  typedef struct packed {
    logic [ID_W-1:0]         drone_echo;
    logic                    first_sample;
    logic signed [PWR_W-1:0] power_estimate;
    logic signed [PWR_W-1:0] innovation;
    logic [PWR_W-1:0]        correction;
    logic [PWR_W-1:0]        nis;
    logic                    spoof_flag;
  } skd_out_t;

  // Divider request: remainder seed (must be below divisor) and 17 low bits
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] divisor;
    logic [DIV_W-1:0] rem_init;
    logic [DIV_W-1:0] low;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: rtl/skd_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, DIV_W steps.
module skd_div
  import skd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     low_r;
  logic [DIV_W-1:0]     quot_r;
  logic [DIV_W-1:0]     div_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           fits;

  // One trial subtract per step
  always_comb begin
    trial = {rem_r, low_r[DIV_W-1]};
    diff  = trial - {1'b0, div_r};
    fits  = trial >= {1'b0, div_r};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CNT_W'(DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.rem_init;
      low_r  <= req.low;
      div_r  <= req.divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      low_r  <= {low_r[DIV_W-2:0], 1'b0};
      quot_r <= {quot_r[DIV_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

FILE: rtl/scalar_kalman_spoof_detector_top.sv
// Scalar Kalman spoof detector. One scalar Kalman filter per transmitter slot tracks transmit
// power in signed Q8.8; estimate and variance live in one synchronous RAM (read on accept,
// written back at the end), valid bits in flip-flops cleared by reset, so no clearing pass is
// needed. drone_id selects slot drone_id mod MAX_DRONES. One request is in flight at a time:
// a tracked transmitter passes LOAD, SQ, NST, DIV, MAG, VAR and WB, its time set by the gain and
// NIS divisions (two 17-step restoring dividers, the NIS one started in NST, after the gain one
// in SQ); a first sample goes from LOAD to WB and a sample with zero innovation variance from SQ
// to WB. A finished result sits in the output register, so the next request is taken while it
// waits; the write-back stage only holds when a second result is ready before the first is taken.
module scalar_kalman_spoof_detector_top
  import skd_pkg::*;
#(
  parameter int MAX_DRONES = MAX_DRONES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  skd_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output skd_out_t          out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  // Only ids below ID_RANGE exist, so at most that many slots are reachable
  localparam int NUM_SLOTS = (MAX_DRONES < ID_RANGE) ? MAX_DRONES : ID_RANGE;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int MEM_W     = 2 * PWR_W;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LOAD = 8'b0000_0010,
    ST_SQ   = 8'b0000_0100,
    ST_NST  = 8'b0000_1000,
    ST_DIV  = 8'b0001_0000,
    ST_MAG  = 8'b0010_0000,
    ST_VAR  = 8'b0100_0000,
    ST_WB   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [CFG_W-1:0] proc_noise_r, meas_noise_r, init_var_r, corr_thr_r, nis_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_noise_r <= RST_PROCESS_NOISE;
      meas_noise_r <= RST_MEASUREMENT_NOISE;
      init_var_r   <= RST_INITIAL_VARIANCE;
      corr_thr_r   <= RST_CORRECTION_THRESHOLD;
      nis_thr_r    <= RST_CONSISTENCY_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PROCESS_NOISE:         proc_noise_r <= cfg_wdata;
        CFG_MEASUREMENT_NOISE:     meas_noise_r <= cfg_wdata;
        CFG_INITIAL_VARIANCE:      init_var_r   <= cfg_wdata;
        CFG_CORRECTION_THRESHOLD:  corr_thr_r   <= cfg_wdata;
        CFG_CONSISTENCY_THRESHOLD: nis_thr_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Id to slot map, constant table
  logic [SLOT_W-1:0] slot_tab [ID_RANGE];
  for (genvar g = 0; g < ID_RANGE; g++) begin : g_slot
    assign slot_tab[g] = SLOT_W'(g % MAX_DRONES);
  end

  logic in_fire;
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Request registers
  logic [ID_W-1:0]   id_r;
  logic [PWR_W-1:0]  z_r;
  logic [SLOT_W-1:0] slot_r;
  logic              first_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      id_r   <= in_data.drone_id;
      z_r    <= in_data.measured_power;
      slot_r <= slot_tab[in_data.drone_id];
    end
  end

  // Estimate/variance RAM: {estimate, variance} per slot. Read only on accept,
  // written only in write-back, so the two never touch the same cycle.
  logic [MEM_W-1:0] est_var_mem [NUM_SLOTS];
  logic [MEM_W-1:0] rd_q_r;
  logic             mem_we;
  logic [MEM_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_q_r <= est_var_mem[slot_tab[in_data.drone_id]];
    end
    if (mem_we) begin
      est_var_mem[slot_r] <= mem_wdata;
    end
  end

  // Valid bits
  logic [NUM_SLOTS-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we && first_r) begin
      valid_r[slot_r] <= 1'b1;
    end
  end

  // Predict and innovation from the RAM word
  logic [PWR_W-1:0] x_ld, p_ld, pp_ld;
  logic [PWR_W:0]   pp_sum, s_ld, y_ld, ay_ld;

  always_comb begin
    x_ld   = rd_q_r[MEM_W-1:PWR_W];
    p_ld   = rd_q_r[PWR_W-1:0];
    pp_sum = {1'b0, p_ld} + {1'b0, proc_noise_r};
    pp_ld  = pp_sum[PWR_W] ? '1 : pp_sum[PWR_W-1:0];
    s_ld   = {1'b0, pp_ld} + {1'b0, meas_noise_r};
    y_ld   = {z_r[PWR_W-1], z_r} - {x_ld[PWR_W-1], x_ld};
    ay_ld  = y_ld[PWR_W] ? (~y_ld + 1'b1) : y_ld;
  end

  logic [PWR_W-1:0] x_r, pp_r;
  logic [PWR_W:0]   s_r, y_r, ay_r;
  logic             szero_r, nsat_r;
  logic [DIV_W-1:0] mag_r;

  // Shared multiplier, registered product
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic              mul_en;
  logic [PROD_W-1:0] prod_r, rnd_sum;

  assign rnd_sum = prod_r + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // Gain and NIS dividers
  div_req_t kreq, nreq;
  div_rsp_t krsp, nrsp;

  skd_div u_kdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (kreq),
    .rsp   (krsp)
  );

  skd_div u_ndiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nreq),
    .rsp   (nrsp)
  );

  // Output register
  logic     out_valid_r;
  skd_out_t out_data_r;

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    kreq      = '0;
    nreq      = '0;
    mem_we    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = valid_r[slot_r] ? ST_SQ : ST_WB;
      end
      ST_SQ: begin
        // y*y into the multiplier, K = Pp<<16 / S into the first divider
        mul_en        = 1'b1;
        mul_a         = ay_r;
        mul_b         = ay_r;
        kreq.start    = (s_r != '0);
        kreq.divisor  = s_r;
        kreq.rem_init = {2'b00, pp_r[PWR_W-1:1]};
        kreq.low      = {pp_r[0], {PWR_W{1'b0}}};
        state_nxt     = (s_r == '0) ? ST_WB : ST_NST;
      end
      ST_NST: begin
        // NIS = y*y / S; the quotient only fits 16 bits when (y*y)>>16 < S
        nreq.start    = 1'b1;
        nreq.divisor  = s_r;
        nreq.rem_init = {2'b00, prod_r[31:17]};
        nreq.low      = prod_r[16:0];
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (krsp.done && nrsp.done) state_nxt = ST_MAG;
      end
      ST_MAG: begin
        mul_en    = 1'b1;
        mul_a     = krsp.quot;
        mul_b     = ay_r;
        state_nxt = ST_VAR;
      end
      ST_VAR: begin
        mul_en    = 1'b1;
        mul_a     = K_ONE - krsp.quot;
        mul_b     = {1'b0, pp_r};
        state_nxt = ST_WB;
      end
      ST_WB: begin
        mem_we = 1'b1;
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      first_r <= !valid_r[slot_r];
      x_r     <= x_ld;
      pp_r    <= pp_ld;
      s_r     <= s_ld;
      y_r     <= y_ld;
      ay_r    <= ay_ld;
    end
    if (state_r == ST_SQ) begin
      szero_r <= (s_r == '0);
    end
    if (state_r == ST_NST) begin
      nsat_r <= {1'b0, prod_r[31:16]} >= s_r;
    end
    if (state_r == ST_VAR) begin
      mag_r <= rnd_sum[32:16];
    end
  end

  // Write-back values and result
  logic [PWR_W+1:0] x_ext, mag_ext, x_sum;
  logic [PWR_W-1:0] x_upd, innov_sat, corr_sat, nis_val, est_wb, var_wb;
  skd_out_t         res;

  always_comb begin
    x_ext   = {{2{x_r[PWR_W-1]}}, x_r};
    mag_ext = {1'b0, mag_r};
    x_sum   = y_r[PWR_W] ? (x_ext - mag_ext) : (x_ext + mag_ext);
    if (!x_sum[PWR_W+1] && (x_sum[PWR_W:PWR_W-1] != 2'b00)) begin
      x_upd = 16'h7FFF;
    end else if (x_sum[PWR_W+1] && (x_sum[PWR_W:PWR_W-1] != 2'b11)) begin
      x_upd = 16'h8000;
    end else begin
      x_upd = x_sum[PWR_W-1:0];
    end

    if (y_r[PWR_W] != y_r[PWR_W-1]) begin
      innov_sat = y_r[PWR_W] ? 16'h8000 : 16'h7FFF;
    end else begin
      innov_sat = y_r[PWR_W-1:0];
    end

    corr_sat = mag_r[DIV_W-1] ? '1 : mag_r[PWR_W-1:0];
    nis_val  = nsat_r ? '1 : nrsp.quot[PWR_W-1:0];

    res.drone_echo = id_r;
    if (first_r) begin
      // First sight: load the filter, report zero innovation, correction and NIS
      est_wb           = z_r;
      var_wb           = init_var_r;
      res.first_sample = 1'b1;
      res.innovation   = '0;
      res.correction   = '0;
      res.nis          = '0;
    end else if (szero_r) begin
      // Zero innovation variance: state held, NIS pinned
      est_wb           = x_r;
      var_wb           = pp_r;
      res.first_sample = 1'b0;
      res.innovation   = innov_sat;
      res.correction   = '0;
      res.nis          = (ay_r != '0) ? '1 : '0;
    end else begin
      est_wb           = x_upd;
      var_wb           = rnd_sum[31:16];
      res.first_sample = 1'b0;
      res.innovation   = innov_sat;
      res.correction   = corr_sat;
      res.nis          = nis_val;
    end
    res.power_estimate = est_wb;
    res.spoof_flag     = !first_r &&
                         ((res.correction > corr_thr_r) || (res.nis > nis_thr_r));
    mem_wdata          = {est_wb, var_wb};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_WB && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WB && out_free) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/skd_checker.sv
`include "assert_macros.svh"

// Port-level checks for the spoof detector
module skd_checker
  import skd_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input skd_out_t out_data
);

  // Any nonzero report field on a result
  logic first_dirty;
  assign first_dirty = (out_data.correction != '0) || (out_data.nis != '0) ||
                       (out_data.innovation != '0) || out_data.spoof_flag;

  // Result channel holds a stalled result
  `SKD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `SKD_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_data), "held result changed")

  // Reset leaves no result pending and the input open
  `SKD_ASSERT_RST(a_rst_state, !rst_n |=> !out_valid && in_ready, "bad state after reset")

  // One request in flight: accepting closes the input
  `SKD_ASSERT(a_one_req, in_valid && in_ready |=> !in_ready, "second request taken while busy")

  // A first sample reports no correction, NIS, innovation or flag
  `SKD_ASSERT(a_first_clean, out_valid && out_data.first_sample |-> !first_dirty, "dirty first")

endmodule

bind scalar_kalman_spoof_detector_top skd_checker u_skd_checker (.*);

FILE: bench/tb_scalar_kalman_spoof_detector_top.sv
module tb_scalar_kalman_spoof_detector_top;
  import skd_pkg::*;

  localparam int TRACKS         = MAX_DRONES_DEF;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 135;

  // Register indexes past the end of the map; writes there must be dropped
  localparam logic [CFG_AW-1:0] CFG_SPARE_5 = CFG_AW'(5);
  localparam logic [CFG_AW-1:0] CFG_SPARE_6 = CFG_AW'(6);
  localparam logic [CFG_AW-1:0] CFG_SPARE_7 = CFG_AW'(7);

  typedef enum logic [1:0] {
    ROW_REQ,  // request, checked against the filter model
    ROW_CHK,  // request with the result typed in
    ROW_CFG   // register write: id holds the index, value the data
  } row_kind_t;

  typedef struct {
    row_kind_t       kind;
    logic [ID_W-1:0] id;
    logic [15:0]     value;
    skd_out_t        want;
  } stim_row_t;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  skd_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  skd_out_t         out_data;
  logic             cfg_we    = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Filter model: register copies and per-transmitter track state
  logic [CFG_W-1:0] q_noise  = RST_PROCESS_NOISE;
  logic [CFG_W-1:0] r_noise  = RST_MEASUREMENT_NOISE;
  logic [CFG_W-1:0] p_init   = RST_INITIAL_VARIANCE;
  logic [CFG_W-1:0] corr_thr = RST_CORRECTION_THRESHOLD;
  logic [CFG_W-1:0] nis_thr  = RST_CONSISTENCY_THRESHOLD;
  bit               track_seen [TRACKS];
  longint           track_est  [TRACKS];
  longint unsigned  track_var  [TRACKS];

  skd_out_t tracked_results [$];
  int       mismatch_count = 0;
  int       idle_cycles    = 0;
  bit       calm           = 1'b0;

  stim_row_t directed_rows [$] = '{
    '{ROW_CHK, 8'd0,   16'h0000, '{8'd0,   1'b1, 16'h0000, 16'h0, 16'h0, 16'h0, 1'b0}},
    '{ROW_CHK, 8'd255, 16'h7FFF, '{8'd255, 1'b1, 16'h7FFF, 16'h0, 16'h0, 16'h0, 1'b0}},
    '{ROW_CHK, 8'd128, 16'h8000, '{8'd128, 1'b1, 16'h8000, 16'h0, 16'h0, 16'h0, 1'b0}},
    '{ROW_CHK, 8'd0,   16'h0000, '{8'd0,   1'b0, 16'h0000, 16'h0, 16'h0, 16'h0, 1'b0}},
    '{ROW_REQ, 8'd255, 16'h8000, '0},
    '{ROW_REQ, 8'd128, 16'h7FFF, '0},
    '{ROW_REQ, 8'd0,   16'h0600, '0},
    '{ROW_REQ, 8'd0,   16'h0100, '0},
    '{ROW_CHK, 8'd1,   16'h0A5A, '{8'd1,   1'b1, 16'h0A5A, 16'h0, 16'h0, 16'h0, 1'b0}},
    '{ROW_REQ, 8'd1,   16'hF5A5, '0},
    '{ROW_CFG, ID_W'(CFG_SPARE_5), 16'hFFFF, '0},
    '{ROW_CFG, ID_W'(CFG_SPARE_6), 16'hA5A5, '0},
    '{ROW_CFG, ID_W'(CFG_SPARE_7), 16'h5A5A, '0},
    '{ROW_REQ, 8'd1,   16'h0A5A, '0},
    // zero innovation variance: Q, R and the initial variance all zero
    '{ROW_CFG, ID_W'(CFG_PROCESS_NOISE),     16'h0000, '0},
    '{ROW_CFG, ID_W'(CFG_MEASUREMENT_NOISE), 16'h0000, '0},
    '{ROW_CFG, ID_W'(CFG_INITIAL_VARIANCE),  16'h0000, '0},
    '{ROW_CHK, 8'd10,  16'h1234, '{8'd10,  1'b1, 16'h1234, 16'h0, 16'h0, 16'h0, 1'b0}},
    '{ROW_CHK, 8'd10,  16'h1234, '{8'd10,  1'b0, 16'h1234, 16'h0, 16'h0, 16'h0, 1'b0}},
    '{ROW_CHK, 8'd10,  16'h1334, '{8'd10,  1'b0, 16'h1234, 16'h0100, 16'h0, 16'hFFFF, 1'b1}},
    // unit gain with R zero, then the variance collapses to zero
    '{ROW_CFG, ID_W'(CFG_INITIAL_VARIANCE),  16'hFFFF, '0},
    '{ROW_CHK, 8'd12,  16'hC000, '{8'd12,  1'b1, 16'hC000, 16'h0, 16'h0, 16'h0, 1'b0}},
    '{ROW_REQ, 8'd12,  16'h4000, '0},
    '{ROW_REQ, 8'd12,  16'h4100, '0}
  };

  scalar_kalman_spoof_detector_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic signed [PWR_W-1:0] clamp_s16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[PWR_W-1:0];
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Register value: one of the extremes or a value in the usual span
  function automatic logic [CFG_W-1:0] pick_cfg(input int unsigned lo, input int unsigned hi);
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return CFG_W'($urandom_range(lo, hi));
  endfunction

  // One predict/update step of the per-transmitter filter
  function automatic skd_out_t track_power(input skd_in_t req);
    int unsigned     slot;
    longint          z, x, y;
    longint unsigned ay, pp, s, gain, mag, nis;
    skd_out_t        res;
    slot = req.drone_id % TRACKS;
    z = $signed(req.measured_power);
    res = '0;
    res.drone_echo = req.drone_id;
    if (!track_seen[slot]) begin
      track_seen[slot] = 1'b1;
      track_est[slot] = z;
      track_var[slot] = p_init;
      res.first_sample = 1'b1;
      res.power_estimate = req.measured_power;
      return res;
    end
    x = track_est[slot];
    pp = track_var[slot] + q_noise;
    if (pp > 65535) pp = 65535;
    s = pp + r_noise;
    y = z - x;
    ay = (y < 0) ? -y : y;
    if (s == 0) begin
      // no innovation variance: gain zero, track holds
      mag = 0;
      nis = (ay != 0) ? 65535 : 0;
      track_var[slot] = pp;
    end else begin
      gain = (pp << 16) / s;
      mag = (gain * ay + 32768) >> 16;
      nis = (ay * ay) / s;
      if (nis > 65535) nis = 65535;
      track_var[slot] = (((65536 - gain) * pp + 32768) >> 16) & 64'hFFFF;
      x = (y < 0) ? x - longint'(mag) : x + longint'(mag);
      track_est[slot] = clamp_s16(x);
      x = track_est[slot];
    end
    if (mag > 65535) mag = 65535;
    res.power_estimate = x[PWR_W-1:0];
    res.innovation = clamp_s16(y);
    res.correction = mag[PWR_W-1:0];
    res.nis = nis[PWR_W-1:0];
    res.spoof_flag = (mag > corr_thr) || (nis > nis_thr);
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Send one request and queue its expected result once accepted
  task automatic push_request(input skd_in_t req, input bit typed, input skd_out_t want);
    int unsigned gap;
    skd_out_t    predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predicted = track_power(req);
    tracked_results.push_back(typed ? want : predicted);
  endtask

  // Drain all results and let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (tracked_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      CFG_PROCESS_NOISE:         q_noise = data;
      CFG_MEASUREMENT_NOISE:     r_noise = data;
      CFG_INITIAL_VARIANCE:      p_init = data;
      CFG_CORRECTION_THRESHOLD:  corr_thr = data;
      CFG_CONSISTENCY_THRESHOLD: nis_thr = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result sink: random back-pressure
  initial begin
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    skd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tracked_results.size() == 0) begin
        flag_mismatch("unrequested result, drone_echo", 16'(out_data.drone_echo), '0);
      end else begin
        want = tracked_results.pop_front();
        if (out_data.drone_echo !== want.drone_echo)
          flag_mismatch("drone_echo", 16'(out_data.drone_echo), 16'(want.drone_echo));
        if (out_data.first_sample !== want.first_sample)
          flag_mismatch("first_sample", 16'(out_data.first_sample), 16'(want.first_sample));
        if (out_data.power_estimate !== want.power_estimate)
          flag_mismatch("power_estimate", out_data.power_estimate, want.power_estimate);
        if (out_data.innovation !== want.innovation)
          flag_mismatch("innovation", out_data.innovation, want.innovation);
        if (out_data.correction !== want.correction)
          flag_mismatch("correction", out_data.correction, want.correction);
        if (out_data.nis !== want.nis)
          flag_mismatch("nis", out_data.nis, want.nis);
        if (out_data.spoof_flag !== want.spoof_flag)
          flag_mismatch("spoof_flag", 16'(out_data.spoof_flag), 16'(want.spoof_flag));
      end
    end
  end

  // Watchdog: too long with no request or result moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases
  initial begin
    skd_in_t         req;
    longint          aim;
    int unsigned     roll;
    int unsigned     slot;
    logic [ID_W-1:0] watch_ids [8];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[i].id[CFG_AW-1:0], directed_rows[i].value);
      end else begin
        req.drone_id = directed_rows[i].id;
        req.measured_power = directed_rows[i].value;
        push_request(req, directed_rows[i].kind == ROW_CHK, directed_rows[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      write_reg(CFG_PROCESS_NOISE,         pick_cfg(0, 96));
      write_reg(CFG_MEASUREMENT_NOISE,     pick_cfg(64, 4096));
      write_reg(CFG_INITIAL_VARIANCE,      pick_cfg(256, 8192));
      write_reg(CFG_CORRECTION_THRESHOLD,  pick_cfg(256, 4096));
      write_reg(CFG_CONSISTENCY_THRESHOLD, pick_cfg(256, 4096));
      foreach (watch_ids[j]) watch_ids[j] = ID_W'($urandom_range(0, ID_RANGE - 1));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        calm = (n % 64) >= 48;
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
          // tracked transmitter: small drift, sometimes a spoof-sized jump
          req.drone_id = watch_ids[$urandom_range(0, 7)];
          slot = req.drone_id % TRACKS;
          aim = track_seen[slot] ? track_est[slot] : longint'($urandom_range(0, 16383)) - 12288;
          if ($urandom_range(0, 9) == 0)
            aim = aim + ($urandom_range(0, 1) ? 1 : -1) * longint'($urandom_range(2048, 8192));
          else
            aim = aim + longint'($urandom_range(0, 1024)) - 512;
          req.measured_power = clamp_s16(aim);
        end else if (roll < 95) begin
          req.drone_id = ID_W'($urandom_range(0, ID_RANGE - 1));
          req.measured_power = PWR_W'($urandom_range(0, 65535));
        end else begin
          req.drone_id = watch_ids[$urandom_range(0, 7)];
          req.measured_power = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        push_request(req, 1'b0, '0);
      end
    end

    calm = 1'b0;
    settle();
    if (mismatch_count == 0 && tracked_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: scalar_kalman_spoof_detector_top.f
+incdir+rtl
rtl/skd_pkg.sv
rtl/skd_div.sv
rtl/scalar_kalman_spoof_detector_top.sv
rtl/skd_checker.sv
bench/tb_scalar_kalman_spoof_detector_top.sv
